FILE: rtl/rfm_pkg.sv
// ----------------------------------------------------------------------------
// rfm_pkg - shared constants for the range filtered median block
// Sizes of the sample store, counter widths, register map and field widths.
// ----------------------------------------------------------------------------
package rfm_pkg;

    // sample store capacity
    localparam int MAX_SAMPLES = 64;
    localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // field widths
    localparam int DATA_W      = 32;
    localparam int KEPT_W      = 7;
    localparam int M_TDATA_W   = 40;

    // configuration register map, index is paddr[2]
    localparam int  PADDR_W     = 3;
    localparam logic REG_MIN_IDX = 1'b0;
    localparam logic REG_MAX_IDX = 1'b1;

    localparam logic [DATA_W-1:0] MIN_RESET = '0;
    localparam logic [DATA_W-1:0] MAX_RESET = '1;

endpackage

FILE: rtl/range_filtered_median.sv
// Result: after the last sample of a set the result is found by a bitwise rank
// search that scans the single-read-port sample store once per result bit, once
// for an odd kept count and twice for an even one; with none kept it is skipped.
// Throughput: one sample per cycle while loading; input stalls during search
// and until the result register is free.
// Reset: synchronous active low; control state, valid and ranges reset, store kept.
// ----------------------------------------------------------------------------
// range_filtered_median - median of the in-range samples of a set
// Stores in-range samples, then finds the middle rank(s) by a bit-serial
// rank search over the store and emits median, kept count and overflow.
// ----------------------------------------------------------------------------
module range_filtered_median (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rfm_pkg::DATA_W-1:0]    s_tdata,   // [31:0] duration
    input  logic                          s_tlast,   // last_sample
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rfm_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] median, [38:32] kept_count
    output logic                          m_tuser,   // overflow
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rfm_pkg::*;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [DATA_W-1:0] min_reg, max_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              pend_reg, pend_next;
    logic              sel_reg, sel_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [DATA_W-1:0] hi_mask_reg, hi_mask_next;
    logic [DATA_W-1:0] bit_reg, bit_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;

    logic [DATA_W-1:0] mem [MAX_SAMPLES];
    logic [DATA_W-1:0] rd_data_reg;

    logic              in_xfer, cfg_wr, keep, full, store_en, match, out_free;
    logic [DATA_W-1:0] res_val;
    logic [DATA_W:0]   sum;

    // handshakes
    assign s_tready = (state_reg == ST_LOAD);
    assign in_xfer  = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_MAX_IDX) ? max_reg : min_reg;

    // range filter and store room
    assign keep     = (s_tdata >= min_reg) && (s_tdata <= max_reg);
    assign full     = (count_reg == CNT_W'(MAX_SAMPLES));
    assign store_en = in_xfer && keep && !full;

    // element counts toward the current rank search bit
    assign match = ((((rd_data_reg ^ r_reg) & hi_mask_reg) == '0)
                   && ((rd_data_reg & bit_reg) == '0));

    assign out_free = !m_tvalid_reg || m_tready;
    assign sum      = {1'b0, a_reg} + {1'b0, b_reg} + (DATA_W+1)'(1);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = 1'b0;
        sel_next      = sel_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        r_next        = r_reg;
        hi_mask_next  = hi_mask_reg;
        bit_next      = bit_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        res_val       = r_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (keep && !full) count_next = count_reg + CNT_W'(1);
                    if (keep && full)  ovf_next   = 1'b1;
                    if (s_tlast)       state_next = ST_START;
                end
            end
            ST_START: begin
                scan_idx_next = '0;
                cnt_next      = '0;
                sel_next      = 1'b0;
                r_next        = '0;
                hi_mask_next  = '0;
                bit_next      = {1'b1, {(DATA_W-1){1'b0}}};
                k_next        = (count_reg - CNT_W'(1)) >> 1;
                if (count_reg == '0) begin
                    a_next     = '0;
                    b_next     = '0;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (pend_reg && match) cnt_next = cnt_reg + CNT_W'(1);
                if (scan_idx_reg == count_reg) begin
                    state_next = ST_DECIDE;
                end else begin
                    pend_next     = 1'b1;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
            end
            ST_DECIDE: begin
                // pick this result bit and narrow the rank
                if (k_reg >= cnt_reg) begin
                    res_val = r_reg | bit_reg;
                    k_next  = k_reg - cnt_reg;
                end
                r_next        = res_val;
                scan_idx_next = '0;
                cnt_next      = '0;
                if (bit_reg[0]) begin
                    if (!sel_reg) begin
                        a_next = res_val;
                        if (count_reg[0]) begin
                            b_next     = res_val;
                            state_next = ST_DONE;
                        end else begin
                            sel_next     = 1'b1;
                            k_next       = count_reg >> 1;
                            r_next       = '0;
                            hi_mask_next = '0;
                            bit_next     = {1'b1, {(DATA_W-1){1'b0}}};
                            state_next   = ST_SCAN;
                        end
                    end else begin
                        b_next     = res_val;
                        state_next = ST_DONE;
                    end
                end else begin
                    bit_next     = bit_reg >> 1;
                    hi_mask_next = {1'b1, hi_mask_reg[DATA_W-1:1]};
                    state_next   = ST_SCAN;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, KEPT_W'(count_reg), sum[DATA_W:1]};
                    m_tuser_next  = ovf_reg;
                    count_next    = '0;
                    ovf_next      = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            sel_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            min_reg      <= MIN_RESET;
            max_reg      <= MAX_RESET;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            pend_reg     <= pend_next;
            sel_reg      <= sel_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr && paddr[2] == REG_MIN_IDX) min_reg <= pwdata;
            if (cfg_wr && paddr[2] == REG_MAX_IDX) max_reg <= pwdata;
        end
    end

    // search datapath and output payload
    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        cnt_reg      <= cnt_next;
        k_reg        <= k_next;
        r_reg        <= r_next;
        hi_mask_reg  <= hi_mask_next;
        bit_reg      <= bit_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // sample store, one write and one registered read
    always_ff @(posedge aclk) begin
        if (store_en) mem[count_reg[ADDR_W-1:0]] <= s_tdata;
        rd_data_reg <= mem[scan_idx_reg[ADDR_W-1:0]];
    end

    // checks
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("stored count beyond capacity");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovf_reg) |-> $past(count_reg) == CNT_W'(MAX_SAMPLES))
        else $error("overflow raised while store had room");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> scan_idx_reg <= count_reg)
        else $error("scan index past stored count");

    a_rank_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_DECIDE) |-> k_reg < count_reg)
        else $error("rank outside stored samples");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside completion");

endmodule

FILE: verif/median_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_checker - scoreboard for the range filtered median block
// Follows the range registers over the APB port and keeps its own copy of the
// in-range samples of each set. At every last-marked sample it computes the
// median, kept count and overflow flag, queues them, and checks each result
// transfer against the oldest queued summary, field by field.
// ----------------------------------------------------------------------------
module median_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [rfm_pkg::DATA_W-1:0]    s_tdata,   // [31:0] duration
    input  logic                          s_tlast,   // last_sample
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rfm_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] median, [38:32] kept_count
    input  logic                          m_tuser,   // overflow
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          pready,
    output int                            mismatches,
    output int                            results_pending
);
    import rfm_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] median;
        logic [KEPT_W-1:0] kept;
        logic              overflow;
    } set_summary_t;

    logic [DATA_W-1:0] min_keep;
    logic [DATA_W-1:0] max_keep;
    logic [DATA_W-1:0] kept_samples [MAX_SAMPLES];
    int                kept_n;
    logic              dropped;
    set_summary_t      summary_q [$];

    // sort a copy of the stored samples and take the middle, half up for pairs
    function automatic logic [DATA_W-1:0] median_of_kept(input int n);
        logic [DATA_W-1:0] sorted [MAX_SAMPLES];
        logic [DATA_W-1:0] key;
        logic [DATA_W:0]   pair_sum;
        int                j;
        if (n == 0)
            return '0;
        for (int i = 0; i < n; i++)
            sorted[i] = kept_samples[i];
        for (int i = 1; i < n; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        if (n % 2 == 1)
            return sorted[n/2];
        pair_sum = {1'b0, sorted[n/2-1]} + {1'b0, sorted[n/2]} + 1'b1;
        return pair_sum[DATA_W:1];
    endfunction

    always @(posedge aclk) begin
        set_summary_t want;
        logic [DATA_W-1:0] got_median;
        logic [KEPT_W-1:0] got_kept;
        if (!aresetn) begin
            min_keep = MIN_RESET;
            max_keep = MAX_RESET;
            kept_n   = 0;
            dropped  = 1'b0;
            summary_q.delete();
        end else begin
            // register write on the access cycle
            if (psel && penable && pwrite && pready) begin
                if (paddr[PADDR_W-1] == REG_MIN_IDX)
                    min_keep = pwdata;
                else
                    max_keep = pwdata;
            end

            // sample transfer: filter, store, close the set on last
            if (s_tvalid && s_tready) begin
                if (s_tdata >= min_keep && s_tdata <= max_keep) begin
                    if (kept_n < MAX_SAMPLES) begin
                        kept_samples[kept_n] = s_tdata;
                        kept_n++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                if (s_tlast) begin
                    want.median   = median_of_kept(kept_n);
                    want.kept     = KEPT_W'(kept_n);
                    want.overflow = dropped;
                    summary_q.insert(summary_q.size(), want);
                    kept_n  = 0;
                    dropped = 1'b0;
                end
            end

            // result transfer against the oldest summary
            if (m_tvalid && m_tready) begin
                got_median = m_tdata[DATA_W-1:0];
                got_kept   = m_tdata[DATA_W +: KEPT_W];
                if (summary_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h kept %0d ovf %b",
                             $time, got_median, got_kept, m_tuser);
                    mismatches++;
                end else begin
                    want = summary_q.pop_front();
                    if (got_median !== want.median) begin
                        $display("%0t: median mismatch, expected %h, got %h",
                                 $time, want.median, got_median);
                        mismatches++;
                    end
                    if (got_kept !== want.kept) begin
                        $display("%0t: kept_count mismatch, expected %0d, got %0d",
                                 $time, want.kept, got_kept);
                        mismatches++;
                    end
                    if (m_tuser !== want.overflow) begin
                        $display("%0t: overflow mismatch, expected %b, got %b",
                                 $time, want.overflow, m_tuser);
                        mismatches++;
                    end
                end
            end
        end
        results_pending <= summary_q.size();
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - stimulus and verdict for the range filtered median block
// Drives sets of duration samples under a series of range windows (defaults,
// narrow, single value at both extremes, empty, random) with random gaps on
// both streams and one long result hold-off; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import rfm_pkg::*;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int LONG_HOLD      = 800;
    localparam logic [PADDR_W-1:0] ADDR_MIN = {REG_MIN_IDX, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_MAX = {REG_MAX_IDX, 2'b00};

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    int                     mismatches;
    int                     results_pending;
    int                     quiet_cycles = 0;
    int                     hold_requests = 0;
    int                     holds_done = 0;
    bit                     steady = 1'b0;
    logic [DATA_W-1:0]      window_lo = MIN_RESET;
    logic [DATA_W-1:0]      window_hi = MAX_RESET;
    logic [DATA_W-1:0]      prev_value = '0;

    always #10 aclk = ~aclk;

    range_filtered_median dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] duration
        .s_tlast  (s_tlast),   // last_sample
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] median, [38:32] kept_count
        .m_tuser  (m_tuser),   // overflow
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    median_checker u_median_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mostly small sets, a few near or past the store capacity
    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 8);
        if (r < 95) return $urandom_range(9, 24);
        return $urandom_range(60, 80);
    endfunction

    // sample value aimed at the current window, its edges and beyond
    function automatic logic [DATA_W-1:0] pick_value();
        logic [63:0]       span;
        logic [63:0]       offset;
        logic [DATA_W-1:0] v;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 50 && window_lo <= window_hi) begin
            span   = {32'b0, window_hi} - {32'b0, window_lo} + 64'd1;
            offset = {$urandom, $urandom} % span;
            v      = window_lo + offset[DATA_W-1:0];
        end else if (r < 55) begin
            v = window_lo;
        end else if (r < 60) begin
            v = window_hi;
        end else if (r < 65) begin
            v = window_lo - 1'b1;
        end else if (r < 70) begin
            v = window_hi + 1'b1;
        end else if (r < 85) begin
            v = prev_value;
        end else begin
            v = $urandom;
        end
        prev_value = v;
        return v;
    endfunction

    // one sample transfer, optional idle before it
    task automatic send_sample(input logic [DATA_W-1:0] d, input logic l);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_set(input int size);
        for (int i = 0; i < size; i++)
            send_sample(pick_value(), i == size - 1);
    endtask

    task automatic run_sets(input int target);
        int sent;
        int sz;
        sent = 0;
        while (sent < target) begin
            sz = pick_size();
            send_set(sz);
            sent += sz;
        end
    endtask

    // stop sending and wait for the block to drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // apb write: setup then access
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
        settle();
        reg_write(ADDR_MIN, lo);
        reg_write(ADDR_MAX, hi);
        window_lo = lo;
        window_hi = hi;
    endtask

    // result side: random ready with gaps, plus requested long hold-offs
    initial begin
        int run;
        int g;
        forever begin
            if (hold_requests > holds_done) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                run = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6)
                                                  : $urandom_range(10, 40);
                m_tready <= 1'b1;
                repeat (run) @(posedge aclk);
                g = gap_len();
                if (g > 0) begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge aclk);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either stream
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, results_pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] base;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset window: single zero, top values, rounding, odd set
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFE, 1'b1);
        send_sample(32'd1, 1'b0);
        send_sample(32'd2, 1'b1);
        send_sample(32'd3, 1'b0);
        send_sample(32'd1, 1'b0);
        send_sample(32'd2, 1'b1);
        send_sample(32'hAAAA_AAAA, 1'b0);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'd7, 1'b0);
        send_sample(32'd7, 1'b1);

        // directed, narrow window: edges, nothing kept
        set_window(32'd10, 32'd20);
        send_sample(32'd9, 1'b0);
        send_sample(32'd10, 1'b0);
        send_sample(32'd20, 1'b0);
        send_sample(32'd21, 1'b1);
        send_sample(32'd5, 1'b1);
        send_sample(32'd21, 1'b0);
        send_sample(32'd10, 1'b1);

        // directed, empty range
        set_window(32'd20, 32'd10);
        send_sample(32'd15, 1'b0);
        send_sample(32'd10, 1'b0);
        send_sample(32'd20, 1'b1);

        // full window: overflowing and exactly full sets, then random sets
        set_window(MIN_RESET, MAX_RESET);
        send_set(72);
        send_set(64);
        run_sets(70);

        // result side held off while samples keep coming
        set_window(32'd100, 32'd1000);
        hold_requests++;
        run_sets(80);

        // single value windows at both extremes, no idling at the low one
        steady = 1'b1;
        set_window(32'h0000_0000, 32'h0000_0000);
        run_sets(50);
        steady = 1'b0;
        set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_sets(50);

        // empty range
        set_window(32'd5000, 32'd10);
        run_sets(30);

        // random wide window, then a small window with many repeats
        a = $urandom;
        b = $urandom;
        set_window((a < b) ? a : b, (a < b) ? b : a);
        run_sets(50);
        base = $urandom_range(0, 2000);
        set_window(base, base + $urandom_range(0, 40));
        run_sets(50);

        // back to the reset window
        set_window(MIN_RESET, MAX_RESET);
        run_sets(30);

        settle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && results_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
